### rtl/stqg_pkg.sv
// Shared types and constants of the sprite tile quad generator.
package stqg_pkg;

  localparam int unsigned RecipShift = 25;
  localparam int unsigned DivW       = 26;
  localparam int unsigned DivSW      = 17;

  localparam logic signed [15:0] ScreenWQ4 = 16'sd6144;
  localparam logic signed [15:0] ScreenHQ4 = 16'sd3584;

  typedef enum logic [2:0] {
    REG_RECT_LEFT     = 3'd0,
    REG_RECT_TOP      = 3'd1,
    REG_RECT_RIGHT    = 3'd2,
    REG_RECT_BOTTOM   = 3'd3,
    REG_SPRITE_WIDTH  = 3'd4,
    REG_SPRITE_HEIGHT = 3'd5,
    REG_FLIP_MODE     = 3'd6,
    REG_PALETTE_BASE  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_WAIT
  } seq_e;

  typedef enum logic [1:0] {
    JOB_RECIP,
    JOB_TEXQ,
    JOB_SPANQ,
    JOB_NUDGE
  } job_e;

  typedef struct packed {
    logic [7:0] palette_byte;
    logic [7:0] start_point;
    logic [7:0] size_code;
  } in_item_t;

  typedef struct packed {
    logic [8:0]         palette_select;
    logic signed [15:0] quad_x0;
    logic signed [15:0] quad_x1;
    logic signed [15:0] quad_y0;
    logic signed [15:0] quad_y1;
    logic signed [15:0] tex_s0;
    logic signed [15:0] tex_s1;
    logic signed [15:0] tex_t0;
    logic signed [15:0] tex_t1;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivSW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivW-1:0]  quotient;
    logic [DivSW-1:0] remainder;
  } div_rsp_t;

  // Per-dimension derived constants; index 0 is x/s, index 1 is y/t.
  typedef struct packed {
    logic signed [15:0] origin;
    logic signed [16:0] span;
    logic [7:0]         n;
    logic [25:0]        m;     // ceil(2^25 / n)
    logic signed [16:0] q;     // floor(span / n)
    logic [7:0]         r;     // span - q*n
    logic [14:0]        qt;    // 16384 / n
    logic [7:0]         rt;    // 16384 % n
    logic signed [18:0] nud;   // inward texture nudge
    logic               mirror;
  } dim_cfg_t;

  typedef struct packed {
    dim_cfg_t   dx;
    dim_cfg_t   dy;
    logic [7:0] pal_base;
    logic       rect_off;
  } cfg_t;

  function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
    if (v > 28'sd32767) begin
      return 16'sd32767;
    end else if (v < -28'sd32768) begin
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

endpackage

### rtl/stqg_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module stqg_div import stqg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivSW-1:0] rem_q, rem_d;
  logic [DivW-1:0]  quo_q, quo_d;
  logic [DivSW-1:0] dvs_q;
  logic [4:0]       cnt_q;
  logic             run_q, done_q;
  logic [DivSW:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? diff[DivSW-1:0] : trial[DivSW-1:0];
    quo_d = {quo_q[DivW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 5'(DivW - 1);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
      cnt_q <= cnt_q - 5'd1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

### rtl/stqg_cfg.sv
// Configuration registers and the sequencer that derives per-dimension constants.
module stqg_cfg import stqg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o,
  output logic        busy_o
);

  logic signed [15:0] left_q, top_q, right_q, bottom_q;
  logic [7:0]         width_q, height_q, pbase_q;
  logic [1:0]         flip_q;

  seq_e state_q, state_d;
  job_e job_q, job_d;
  logic dim_q, dim_d;

  logic [25:0]        m_q   [2];
  logic signed [16:0] q_q   [2];
  logic [7:0]         r_q   [2];
  logic [14:0]        qt_q  [2];
  logic [7:0]         rt_q  [2];
  logic signed [18:0] nud_q [2];

  logic [7:0]         n_v    [2];
  logic signed [16:0] span_v [2];
  logic [16:0]        abs_v  [2];

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     wr;
  logic     store;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= 16'sd0;
      top_q    <= 16'sd0;
      right_q  <= ScreenWQ4;
      bottom_q <= ScreenHQ4;
      width_q  <= 8'd16;
      height_q <= 8'd16;
      flip_q   <= 2'd0;
      pbase_q  <= 8'd0;
    end else if (wr) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_RECT_LEFT:     left_q   <= cfg_data_i;
        REG_RECT_TOP:      top_q    <= cfg_data_i;
        REG_RECT_RIGHT:    right_q  <= cfg_data_i;
        REG_RECT_BOTTOM:   bottom_q <= cfg_data_i;
        REG_SPRITE_WIDTH:  width_q  <= cfg_data_i[7:0];
        REG_SPRITE_HEIGHT: height_q <= cfg_data_i[7:0];
        REG_FLIP_MODE:     flip_q   <= cfg_data_i[1:0];
        REG_PALETTE_BASE:  pbase_q  <= cfg_data_i[7:0];
      endcase
    end
  end

  // a zero cell count acts as one
  always_comb begin
    n_v[0]    = (width_q == 8'd0) ? 8'd1 : width_q;
    n_v[1]    = (height_q == 8'd0) ? 8'd1 : height_q;
    span_v[0] = 17'(right_q) - 17'(left_q);
    span_v[1] = 17'(bottom_q) - 17'(top_q);
    abs_v[0]  = span_v[0][16] ? 17'(-span_v[0]) : 17'(span_v[0]);
    abs_v[1]  = span_v[1][16] ? 17'(-span_v[1]) : 17'(span_v[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_LOAD;
      job_q   <= JOB_RECIP;
      dim_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      dim_q   <= dim_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    job_d            = job_q;
    dim_d            = dim_q;
    store            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = {9'd0, n_v[dim_q]};
    unique case (job_q)
      JOB_RECIP: div_req.dividend = 26'd33554432 + {18'd0, n_v[dim_q]} - 26'd1;
      JOB_TEXQ:  div_req.dividend = 26'd16384;
      JOB_SPANQ: div_req.dividend = {9'd0, abs_v[dim_q]};
      JOB_NUDGE: begin
        div_req.dividend = 26'd131072;
        div_req.divisor  = abs_v[dim_q];
      end
    endcase
    unique case (state_q)
      SEQ_IDLE: ;
      SEQ_LOAD: begin
        div_req.start = 1'b1;
        state_d       = SEQ_WAIT;
      end
      SEQ_WAIT: begin
        if (div_rsp.done) begin
          store   = 1'b1;
          state_d = SEQ_LOAD;
          unique case (job_q)
            JOB_RECIP: job_d = JOB_TEXQ;
            JOB_TEXQ:  job_d = JOB_SPANQ;
            JOB_SPANQ: job_d = JOB_NUDGE;
            JOB_NUDGE: begin
              job_d = JOB_RECIP;
              dim_d = 1'b1;
              if (dim_q) begin
                state_d = SEQ_IDLE;
                dim_d   = 1'b0;
              end
            end
          endcase
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
    // any write restarts the whole derivation
    if (wr) begin
      state_d = SEQ_LOAD;
      job_d   = JOB_RECIP;
      dim_d   = 1'b0;
    end
  end

  stqg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic               rem_nz;
  logic               neg;
  logic signed [18:0] nd, cap;

  always_comb begin
    rem_nz = div_rsp.remainder != '0;
    neg    = span_v[dim_q][16];
    nd     = neg ? -19'(div_rsp.quotient[17:0]) : 19'(div_rsp.quotient[17:0]);
    cap    = 19'(qt_q[dim_q][14:4]);
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      unique case (job_q)
        JOB_RECIP: m_q[dim_q] <= div_rsp.quotient;
        JOB_TEXQ: begin
          qt_q[dim_q] <= div_rsp.quotient[14:0];
          rt_q[dim_q] <= div_rsp.remainder[7:0];
        end
        JOB_SPANQ: begin
          if (neg) begin
            q_q[dim_q] <= -17'(div_rsp.quotient[16:0]) - (rem_nz ? 17'sd1 : 17'sd0);
            r_q[dim_q] <= rem_nz ? (n_v[dim_q] - div_rsp.remainder[7:0]) : 8'd0;
          end else begin
            q_q[dim_q] <= 17'(div_rsp.quotient[16:0]);
            r_q[dim_q] <= div_rsp.remainder[7:0];
          end
        end
        JOB_NUDGE: begin
          if (span_v[dim_q] == 17'sd0 || nd >= cap) begin
            nud_q[dim_q] <= cap;
          end else begin
            nud_q[dim_q] <= nd;
          end
        end
      endcase
    end
  end

  always_comb begin
    cfg_o.dx.origin = left_q;
    cfg_o.dy.origin = top_q;
    cfg_o.dx.span   = span_v[0];
    cfg_o.dy.span   = span_v[1];
    cfg_o.dx.n      = n_v[0];
    cfg_o.dy.n      = n_v[1];
    cfg_o.dx.m      = m_q[0];
    cfg_o.dy.m      = m_q[1];
    cfg_o.dx.q      = q_q[0];
    cfg_o.dy.q      = q_q[1];
    cfg_o.dx.r      = r_q[0];
    cfg_o.dy.r      = r_q[1];
    cfg_o.dx.qt     = qt_q[0];
    cfg_o.dy.qt     = qt_q[1];
    cfg_o.dx.rt     = rt_q[0];
    cfg_o.dy.rt     = rt_q[1];
    cfg_o.dx.nud    = nud_q[0];
    cfg_o.dy.nud    = nud_q[1];
    cfg_o.dx.mirror = flip_q[0];
    cfg_o.dy.mirror = flip_q[1];
    cfg_o.pal_base  = pbase_q;
    cfg_o.rect_off  = (left_q >= ScreenWQ4) || right_q[15] ||
                      (top_q >= ScreenHQ4) || bottom_q[15];
  end

  assign busy_o = state_q != SEQ_IDLE;

endmodule

### rtl/stqg_pipe.sv
// Seven-stage tile mapping pipeline with output register.
module stqg_pipe import stqg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      busy_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  dim_cfg_t dc [2];
  assign dc[0] = cfg_i.dx;
  assign dc[1] = cfg_i.dy;

  logic en, acc;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, out_vld_q;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = busy_i || !en;
  assign acc        = in_valid_i && !in_stall_o;

  // stage 1: capture
  logic [8:0] pal1_q, pal2_q, pal3_q, pal4_q, pal5_q, pal6_q;
  logic [7:0] start1_q, start2_q;
  logic [4:0] len1_q [2], len2_q [2], len3_q [2];

  // stage 2: row via reciprocal
  logic [33:0] rowp;
  logic [7:0]  row2_q;
  assign rowp = {26'd0, start1_q} * {8'd0, dc[0].m};

  // stage 3: column
  logic [15:0] colp;
  logic [7:0]  c3_q [2];
  assign colp = {8'd0, row2_q} * {8'd0, dc[0].n};

  // stage 4: partial products; e indexes the low/high cell edge
  logic [8:0]         cv [2][2];
  logic signed [26:0] gq4_q [2][2], gq5_q [2][2];
  logic [16:0]        gn4_q [2][2];
  logic [23:0]        tq4_q [2][2], tq5_q [2][2];
  logic [16:0]        tn4_q [2][2];

  // stage 5: fractional parts by reciprocal
  logic [42:0] gp [2][2], tp [2][2];
  logic [16:0] gf5_q [2][2], tf5_q [2][2];

  // stage 6: edges
  logic signed [27:0] ga [2][2];
  logic signed [25:0] ta [2][2];
  logic signed [27:0] e6_q [2][2];
  logic signed [25:0] t6_q [2][2];

  out_item_t out_q;
  logic      keep;

  always_comb begin
    for (int d = 0; d < 2; d++) begin
      cv[d][0] = {1'b0, c3_q[d]};
      cv[d][1] = {1'b0, c3_q[d]} + {4'd0, len3_q[d]};
      for (int e = 0; e < 2; e++) begin
        gp[d][e] = {26'd0, gn4_q[d][e]} * {17'd0, dc[d].m};
        tp[d][e] = {26'd0, tn4_q[d][e]} * {17'd0, dc[d].m};
        ga[d][e] = 28'(gq5_q[d][e]) + 28'($signed({1'b0, gf5_q[d][e]}));
        ta[d][e] = 26'($signed({1'b0, tq5_q[d][e]})) +
                   26'($signed({1'b0, tf5_q[d][e]}));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= acc;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      out_vld_q <= v6_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pal1_q    <= {1'b0, in_data_i.palette_byte} + {1'b0, cfg_i.pal_base};
      start1_q  <= in_data_i.start_point;
      len1_q[0] <= {1'b0, in_data_i.size_code[7:4]} + 5'd1;
      len1_q[1] <= {1'b0, in_data_i.size_code[3:0]} + 5'd1;

      pal2_q   <= pal1_q;
      start2_q <= start1_q;
      len2_q   <= len1_q;
      row2_q   <= rowp[32:25];

      pal3_q   <= pal2_q;
      len3_q   <= len2_q;
      c3_q[0]  <= start2_q - colp[7:0];
      c3_q[1]  <= row2_q;

      pal4_q <= pal3_q;
      for (int d = 0; d < 2; d++) begin
        for (int e = 0; e < 2; e++) begin
          gq4_q[d][e] <= 27'($signed({1'b0, cv[d][e]})) * 27'(dc[d].q);
          // mirrored edges need the ceiling of the fraction
          gn4_q[d][e] <= 17'(cv[d][e]) * 17'(dc[d].r) +
                         (dc[d].mirror ? 17'(dc[d].n - 8'd1) : 17'd0);
          tq4_q[d][e] <= 24'(cv[d][e]) * 24'(dc[d].qt);
          tn4_q[d][e] <= 17'(cv[d][e]) * 17'(dc[d].rt);
        end
      end

      pal5_q <= pal4_q;
      gq5_q  <= gq4_q;
      tq5_q  <= tq4_q;
      for (int d = 0; d < 2; d++) begin
        for (int e = 0; e < 2; e++) begin
          gf5_q[d][e] <= gp[d][e][41:25];
          tf5_q[d][e] <= tp[d][e][41:25];
        end
      end

      pal6_q <= pal5_q;
      for (int d = 0; d < 2; d++) begin
        if (dc[d].mirror) begin
          e6_q[d][0] <= 28'(dc[d].origin) + 28'(dc[d].span) - ga[d][1];
          e6_q[d][1] <= 28'(dc[d].origin) + 28'(dc[d].span) - ga[d][0];
          t6_q[d][0] <= ta[d][1] - 26'(dc[d].nud);
          t6_q[d][1] <= ta[d][0] - 26'(dc[d].nud);
        end else begin
          e6_q[d][0] <= 28'(dc[d].origin) + ga[d][0];
          e6_q[d][1] <= 28'(dc[d].origin) + ga[d][1];
          t6_q[d][0] <= 26'(dc[d].nud) + ta[d][0];
          t6_q[d][1] <= 26'(dc[d].nud) + ta[d][1];
        end
      end

      out_q.palette_select <= pal6_q;
      out_q.quad_x0        <= sat16(e6_q[0][0]);
      out_q.quad_x1        <= sat16(e6_q[0][1]);
      out_q.quad_y0        <= sat16(e6_q[1][0]);
      out_q.quad_y1        <= sat16(e6_q[1][1]);
      out_q.tex_s0         <= sat16(28'(t6_q[0][0]));
      out_q.tex_s1         <= sat16(28'(t6_q[0][1]));
      out_q.tex_t0         <= sat16(28'(t6_q[1][0]));
      out_q.tex_t1         <= sat16(28'(t6_q[1][1]));
    end
  end

  // exact overlap test before saturation
  assign keep = !cfg_i.rect_off &&
                (e6_q[0][0] < 28'(ScreenWQ4)) && !e6_q[0][1][27] &&
                (e6_q[1][0] < 28'(ScreenHQ4)) && !e6_q[1][1][27];

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### rtl/sprite_tile_quad_generator.sv
// Top level of the sprite tile quad generator.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o    | in_data_i  (in_item_t)
//  out     | output    | out_valid_o / out_stall_i  | out_data_o (out_item_t)
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One tile record per cycle unless in_stall_o is high; each transfer yields
// zero or one quad after six compute stages plus the output register.
// Reset and every register write start a derivation pass of eight divisions
// on a shared divider, during which in_stall_o stays high. Register writes
// are taken at any time. A stalled output freezes the whole pipeline;
// nothing is dropped or repeated.
module sprite_tile_quad_generator import stqg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg;
  logic busy;

  // registers plus derived reciprocals, quotients and nudges
  stqg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .busy_o      (busy)
  );

  // per-tile mapping datapath
  stqg_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .busy_i      (busy),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
